FILE: sv/ntc_pkg.sv
// shared types, constants and the resistance table for the ntc converter
// no dependencies
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int unsigned CodeW  = 12;
  localparam int unsigned TempW  = 16;
  localparam int unsigned DvdW   = 27;
  localparam int unsigned DvsW   = 26;
  localparam int unsigned RthW   = 15;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned RomLen = 98;
  localparam int unsigned FracW  = 8;
  localparam int unsigned CntW   = $clog2(DvdW + 1);

  localparam logic [DvdW-1:0] QNumer   = DvdW'(62060606);
  localparam logic [DvdW-1:0] RthNumer = DvdW'(100000000);
  localparam logic [DvsW-1:0] ROffset  = DvsW'(10000);
  localparam logic [CntW-1:0] DivSteps = CntW'(DvdW);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(RomLen - 1);

  localparam logic [RthW-1:0] NtcRom [RomLen] = '{
    15'd28017, 15'd26826, 15'd25697, 15'd24629, 15'd23618, 15'd22660, 15'd21752,
    15'd20892, 15'd20075, 15'd19299, 15'd18560, 15'd18482, 15'd18149, 15'd17632,
    15'd16992, 15'd16280, 15'd15535, 15'd14787, 15'd14055, 15'd13354, 15'd12690,
    15'd12068, 15'd11490, 15'd10954, 15'd10458, 15'd10000, 15'd9576,  15'd9184,
    15'd8819,  15'd8478,  15'd8160,  15'd7861,  15'd7579,  15'd7311,  15'd7056,
    15'd6813,  15'd6581,  15'd6357,  15'd6142,  15'd5934,  15'd5734,  15'd5541,
    15'd5353,  15'd5173,  15'd4998,  15'd4829,  15'd4665,  15'd4507,  15'd4355,
    15'd4208,  15'd4065,  15'd3927,  15'd3794,  15'd3664,  15'd3538,  15'd3415,
    15'd3294,  15'd3175,  15'd3058,  15'd2941,  15'd2825,  15'd2776,  15'd2718,
    15'd2652,  15'd2582,  15'd2508,  15'd2432,  15'd2356,  15'd2280,  15'd2207,
    15'd2135,  15'd2066,  15'd2000,  15'd1938,  15'd1879,  15'd1823,  15'd1770,
    15'd1720,  15'd1673,  15'd1628,  15'd1586,  15'd1546,  15'd1508,  15'd1471,
    15'd1435,  15'd1401,  15'd1367,  15'd1334,  15'd1301,  15'd1268,  15'd1236,
    15'd1204,  15'd1171,  15'd1139,  15'd1107,  15'd1074,  15'd1042,  15'd1010
  };

  function automatic logic [RthW-1:0] ntc_rom_at(input logic [IdxW-1:0] idx);
    logic [RthW-1:0] val;
    val = '0;
    if (idx <= IdxLast) begin
      val = NtcRom[idx];
    end
    return val;
  endfunction

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_Q,
    S_DIV_RTH,
    S_SEARCH,
    S_DIV_FRAC,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_Q,
    OP_RTH,
    OP_FRAC
  } div_op_e;

  typedef struct packed {
    logic    load_in;
    logic    div_load;
    div_op_e div_op;
    logic    div_step;
    logic    search_init;
    logic    search_step;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_done;
    logic search_done;
  } sts_t;

endpackage

FILE: sv/ntc_ctrl.sv
// sequencer for the ntc converter: handshakes and datapath commands
// depends on ntc_pkg
`timescale 1ns / 1ps

module ntc_ctrl import ntc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_op = OP_Q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in  = 1'b1;
          cmd_o.div_load = 1'b1;
          cmd_o.div_op   = OP_Q;
          state_d = sts_i.in_zero ? S_DONE : S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        if (sts_i.div_done) begin
          cmd_o.div_load = 1'b1;
          cmd_o.div_op   = OP_RTH;
          state_d = S_DIV_RTH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIV_RTH: begin
        if (sts_i.div_done) begin
          cmd_o.search_init = 1'b1;
          state_d = S_SEARCH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_SEARCH: begin
        if (sts_i.search_done) begin
          cmd_o.div_load = 1'b1;
          cmd_o.div_op   = OP_FRAC;
          state_d = S_DIV_FRAC;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_DIV_FRAC: begin
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/ntc_dp.sv
// datapath for the ntc converter: shared restoring divider, table search,
// interpolation and result register; depends on ntc_pkg
`timescale 1ns / 1ps

module ntc_dp import ntc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CodeW-1:0] adc_code_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [TempW-1:0] temperature_q8_o,
  output logic             zero_code_error_o
);

  logic [CodeW-1:0] code_q;
  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [DvsW-1:0]  rem_q, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q;
  logic [RthW-1:0]  rth_q;
  logic [IdxW-1:0]  lo_q, hi_q, probe;
  logic [TempW-1:0] res_q;
  logic             err_q;

  logic [DvdW-1:0]  trial, diff;
  logic             qbit;
  logic [DvsW-1:0]  q_res, r_div;
  logic [RthW-1:0]  rom_lo, rom_hi, num;
  logic [IdxW:0]    probe_sum;
  logic [TempW-1:0] interp;

  // divider step
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  // operands for each division
  assign q_res  = dvd_q[DvsW-1:0];
  assign r_div  = (q_res > ROffset) ? (q_res - ROffset) : DvsW'(1);
  assign rom_lo = ntc_rom_at(lo_q);
  assign rom_hi = ntc_rom_at(hi_q);
  assign num    = (rom_lo >= rth_q) ? (rom_lo - rth_q) : '0;

  always_comb begin
    dvd_d = QNumer;
    dvs_d = DvsW'(adc_code_i);
    case (cmd_i.div_op)
      OP_Q: begin
        dvd_d = QNumer;
        dvs_d = DvsW'(adc_code_i);
      end
      OP_RTH: begin
        dvd_d = RthNumer;
        dvs_d = r_div;
      end
      OP_FRAC: begin
        dvd_d = DvdW'({num, {FracW{1'b0}}});
        dvs_d = DvsW'(rom_lo - rom_hi);
      end
      default: begin
        dvd_d = QNumer;
        dvs_d = DvsW'(adc_code_i);
      end
    endcase
  end

  assign probe_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign probe     = probe_sum[IdxW:1];
  assign interp    = TempW'({lo_q, {FracW{1'b0}}}) + dvd_q[TempW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= DivSteps;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      code_q <= adc_code_i;
    end
    if (cmd_i.div_load) begin
      dvd_q <= dvd_d;
      dvs_q <= dvs_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DvdW-2:0], qbit};
      rem_q <= qbit ? diff[DvsW-1:0] : trial[DvsW-1:0];
    end
    if (cmd_i.search_init) begin
      rth_q <= dvd_q[RthW-1:0];
      lo_q  <= '0;
      hi_q  <= IdxLast;
    end else if (cmd_i.search_step) begin
      if (ntc_rom_at(probe) < rth_q) begin
        hi_q <= probe;
      end else begin
        lo_q <= probe;
      end
    end
    if (cmd_i.load_out) begin
      err_q <= (code_q == '0);
      res_q <= (code_q == '0) ? '0 : interp;
    end
  end

  assign sts_o.in_zero     = (adc_code_i == '0);
  assign sts_o.div_done    = (cnt_q == '0);
  assign sts_o.search_done = ((hi_q - lo_q) <= IdxW'(1));

  assign temperature_q8_o  = res_q;
  assign zero_code_error_o = err_q;

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> cnt_q != '0)
    else $error("divider stepped with no iterations left");

  a_search_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search_step |-> (ntc_rom_at(lo_q) >= rth_q) && (lo_q < hi_q))
    else $error("search interval lost its bracket");

  a_search_narrows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search_step |=> (hi_q - lo_q) < $past(hi_q - lo_q))
    else $error("search interval did not shrink");

endmodule

FILE: sv/ntc_adc_to_temperature.sv
// top level of the ntc adc to temperature converter
// depends on ntc_pkg, ntc_ctrl and ntc_dp
`timescale 1ns / 1ps

// One adc_code beat in gives one result beat out: temperature_q8 in table
// degrees with 8 fraction bits, or zero_code_error set with temperature 0 for
// a code of zero. A conversion uses one shared bit-serial divider that runs
// three 27-step divisions (divider quotient, resistance, interpolation
// fraction) plus a binary search of up to 7 steps over the 98-entry
// resistance table. A code of zero skips the divisions and the search. One
// conversion runs at a time; the next input beat is taken while a finished
// result still waits in the output register.

module ntc_adc_to_temperature import ntc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CodeW-1:0] adc_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [TempW-1:0] temperature_q8_o,
  output logic             zero_code_error_o
);

  cmd_t cmd;
  sts_t sts;

  ntc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ntc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adc_code_i        (adc_code_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .temperature_q8_o  (temperature_q8_o),
    .zero_code_error_o (zero_code_error_o)
  );

endmodule
